### hw/rtl/tfcv_pkg.sv
// Package for the TLV frame CRC validator.
// Holds the status codes, the frame state record, header constants and the CRC_A byte step.
// No dependencies.
`default_nettype none

package tfcv_pkg;

  localparam int MAX_FRAME_DEF = 4096;
  localparam int MINLEN_W      = 13;
  localparam logic [MINLEN_W-1:0] MIN_LEN_RESET = 13'd2000;
  // Width for position compares against inner length plus offsets.
  localparam int CMP_W = 18;

  localparam logic [15:0] CRC_INIT    = 16'h6363;
  localparam logic [7:0]  OUTER_TAG0  = 8'h0E;
  localparam logic [7:0]  LONG_FORM   = 8'h82;
  localparam logic [7:0]  INNER_TAG0  = 8'h39;
  localparam logic [7:0]  CRC_TAG0    = 8'h0C;
  localparam logic [7:0]  CRC_TAG_LEN = 8'h02;

  // Header flag bit positions.
  localparam int FL_OUTER = 0;
  localparam int FL_INNER = 1;
  localparam int FL_CTAG  = 2;
  localparam int FL_CDONE = 3;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_LEN      = 3'd2,
    ST_INNER    = 3'd3,
    ST_CRCTAG   = 3'd4,
    ST_CRCBAD   = 3'd5,
    ST_OVERLONG = 3'd6
  } status_t;

  typedef struct packed {
    logic [15:0] outer_len;
    logic [15:0] inner_len;
    logic [15:0] crc;
    logic [15:0] rx_crc;
    logic [3:0]  flags;
    logic        overflow;
  } frame_st_t;

  localparam frame_st_t FRAME_CLEAR = '{
    outer_len: 16'h0000, inner_len: 16'h0000, crc: CRC_INIT,
    rx_crc: 16'h0000, flags: 4'h0, overflow: 1'b0
  };

  // One byte of the reflected CCITT CRC (poly 0x8408), table-free form.
  function automatic logic [15:0] crc_a_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] d;
    d = b ^ crc[7:0];
    d = d ^ {d[3:0], 4'b0000};
    return {d, crc[15:8]} ^ {12'h000, d[7:4]} ^ {5'b00000, d, 3'b000};
  endfunction

endpackage

`default_nettype wire

### hw/rtl/tlv_frame_crc_validator_top.sv
// Top level of the TLV frame CRC validator: input register, byte tracker, status and result register.
// Depends on tfcv_pkg, tfcv_byte_tracker and tfcv_status_eval.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------------
//   in       | in_valid / in_ready  | data_byte[7:0], last
//   out      | out_valid / out_ready| status[2:0], crc_value[15:0], payload_len[15:0]
//   cfg      | cfg_wr_en            | cfg_wr_data[12:0] (min_frame_len)
//
// Each byte beat is accepted into an input register and folded into the frame state in
// the following cycle unless a last byte waits on a stalled result, so the block sustains
// one byte per cycle while no result stalls. The result beat for a frame is loaded into
// the result register when its last byte moves on from the input register. Reset is
// synchronous and clears the frame state and sets min_frame_len to 2000; no clearing pass
// is needed. A stalled result only holds up a following last byte: the input register
// then keeps its beat and in_ready falls until out_ready is seen.
`default_nettype none

module tlv_frame_crc_validator_top
  import tfcv_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [7:0]          data_byte,
  input  wire logic                last,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [2:0]               status,
  output logic [15:0]              crc_value,
  output logic [15:0]              payload_len,
  input  wire logic                cfg_wr_en,
  input  wire logic [MINLEN_W-1:0] cfg_wr_data
);

  localparam int POS_W = $clog2(MAX_FRAME + 1);

  // Input register holding one byte beat.
  logic                s1_valid;
  logic [7:0]          s1_byte;
  logic                s1_last;
  logic                s1_fire;
  logic [MINLEN_W-1:0] min_frame_len;

  frame_st_t           upd;
  logic [POS_W-1:0]    upd_pos;
  status_t             frame_status;

  // A byte that ends a frame may only move on when the result register is free or
  // being emptied in this cycle; other bytes move on at once.
  assign s1_fire  = s1_valid && (!s1_last || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= data_byte;
      s1_last <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_frame_len <= MIN_LEN_RESET;
    end else if (cfg_wr_en) begin
      min_frame_len <= cfg_wr_data;
    end
  end

  tfcv_byte_tracker #(
    .MAX_FRAME (MAX_FRAME),
    .POS_W     (POS_W)
  ) u_tracker (
    .clk       (clk),
    .rst       (rst),
    .byte_en   (s1_fire),
    .data_byte (s1_byte),
    .last      (s1_last),
    .upd       (upd),
    .upd_pos   (upd_pos)
  );

  tfcv_status_eval #(
    .POS_W (POS_W)
  ) u_status (
    .st      (upd),
    .n       (upd_pos),
    .min_len (min_frame_len),
    .status  (frame_status)
  );

  // Result register: loaded from the state as it stands after the last byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last) begin
      status      <= frame_status;
      crc_value   <= upd.crc;
      payload_len <= upd.inner_len;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/tfcv_byte_tracker.sv
// Per-frame state registers and the per-byte update of the frame validator.
// Depends on tfcv_pkg.
`default_nettype none

module tfcv_byte_tracker
  import tfcv_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF,
  parameter int POS_W     = $clog2(MAX_FRAME + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             byte_en,
  input  wire logic [7:0]       data_byte,
  input  wire logic             last,
  output frame_st_t             upd,
  output logic      [POS_W-1:0] upd_pos
);

  frame_st_t        state, state_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [CMP_W-1:0] p_ext, crc_at;

  // The stored inner length serves here: while bytes 6 and 7 bring it in, the
  // position is still below 8 and so below any CRC TLV start.
  assign p_ext  = CMP_W'(pos);
  assign crc_at = CMP_W'(state.inner_len) + CMP_W'(8);

  always_comb begin
    upd     = state;
    upd_pos = pos;
    if (pos == POS_W'(MAX_FRAME)) begin
      upd.overflow = 1'b1;
    end else begin
      upd_pos = pos + POS_W'(1);
      if (p_ext == CMP_W'(0)) begin
        if (data_byte == OUTER_TAG0) upd.flags[FL_OUTER] = 1'b1;
      end else if (p_ext == CMP_W'(1)) begin
        if (data_byte != LONG_FORM) upd.flags[FL_OUTER] = 1'b0;
      end else if (p_ext == CMP_W'(2)) begin
        upd.outer_len = {data_byte, 8'h00};
      end else if (p_ext == CMP_W'(3)) begin
        upd.outer_len[7:0] = data_byte;
      end else if (p_ext == CMP_W'(4)) begin
        if (data_byte == INNER_TAG0) upd.flags[FL_INNER] = 1'b1;
      end else if (p_ext == CMP_W'(5)) begin
        if (data_byte != LONG_FORM) upd.flags[FL_INNER] = 1'b0;
      end else if (p_ext == CMP_W'(6)) begin
        upd.inner_len = {data_byte, 8'h00};
      end else if (p_ext == CMP_W'(7)) begin
        upd.inner_len[7:0] = data_byte;
      end

      if (p_ext >= CMP_W'(4) && p_ext < crc_at)
        upd.crc = crc_a_byte(state.crc, data_byte);

      if (p_ext >= CMP_W'(8)) begin
        if (p_ext == crc_at) begin
          if (data_byte == CRC_TAG0) upd.flags[FL_CTAG] = 1'b1;
        end else if (p_ext == crc_at + CMP_W'(1)) begin
          if (data_byte != CRC_TAG_LEN) upd.flags[FL_CTAG] = 1'b0;
        end else if (p_ext == crc_at + CMP_W'(2)) begin
          upd.rx_crc = {data_byte, 8'h00};
        end else if (p_ext == crc_at + CMP_W'(3)) begin
          upd.rx_crc[7:0]     = data_byte;
          upd.flags[FL_CDONE] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    state_next = state;
    pos_next   = pos;
    if (byte_en) begin
      state_next = last ? FRAME_CLEAR : upd;
      pos_next   = last ? '0 : upd_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FRAME_CLEAR;
      pos   <= '0;
    end else begin
      state <= state_next;
      pos   <= pos_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/tfcv_status_eval.sv
// End-of-frame status decision for the frame validator.
// Depends on tfcv_pkg.
`default_nettype none

module tfcv_status_eval
  import tfcv_pkg::*;
#(
  parameter int POS_W = $clog2(MAX_FRAME_DEF + 1)
) (
  input  frame_st_t                  st,
  input  wire logic [POS_W-1:0]      n,
  input  wire logic [MINLEN_W-1:0]   min_len,
  output status_t                    status
);

  logic [CMP_W-1:0] n_ext;

  assign n_ext = CMP_W'(n);

  // Checks are taken in priority order; the first failure wins.
  always_comb begin
    priority if (st.overflow)
      status = ST_OVERLONG;
    else if (n_ext < CMP_W'(min_len) || n_ext < CMP_W'(2) || !st.flags[FL_OUTER])
      status = ST_SHORT;
    else if (n_ext != CMP_W'(st.outer_len) + CMP_W'(4))
      status = ST_LEN;
    else if (n_ext < CMP_W'(8) || !st.flags[FL_INNER])
      status = ST_INNER;
    else if (!st.flags[FL_CDONE] || !st.flags[FL_CTAG])
      status = ST_CRCTAG;
    else if (st.crc != st.rx_crc)
      status = ST_CRCBAD;
    else
      status = ST_OK;
  end

endmodule

`default_nettype wire

### hw/rtl/tfcv_checker.sv
// Port-level checks for the TLV frame CRC validator, attached by bind to the top level.
// Depends on tfcv_pkg and tlv_frame_crc_validator_top.
`default_nettype none

module tfcv_checker
  import tfcv_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic [7:0]          data_byte,
  input wire logic                last,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [2:0]          status,
  input wire logic [15:0]         crc_value,
  input wire logic [15:0]         payload_len
);

  // An offered byte beat stays offered and unchanged until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(data_byte) && $stable(last))
    else $error("input beat changed while waiting");

  // A result beat held back must keep its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(crc_value)
      && $stable(payload_len))
    else $error("result beat changed while stalled");

  // Only defined status codes are ever reported.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_OVERLONG)
    else $error("undefined status code");

  // With the result register empty the input side never stalls.
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with no result pending");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

endmodule

bind tlv_frame_crc_validator_top tfcv_checker u_tfcv_checker (.*);

`default_nettype wire
